[design/htm_pkg.sv]
// Shared types, constants and the popcount function for the Hamming threshold match block.
// Used by every module in this folder; depends on nothing.
package htm_pkg;

  localparam int IDX_W  = 6;
  localparam int WORD_W = 32;
  localparam int ID_W   = 31;
  localparam int CNT_W  = 12;
  localparam int WPV_W  = 7;
  localparam int POP_W  = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // command codes carried in s_tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  // register indexes (byte address 4*i)
  localparam logic REG_WORDS_PER_VECTOR = 1'b0;
  localparam logic REG_MAX_DISTANCE     = 1'b1;

  localparam logic [WPV_W-1:0] WPV_RESET  = 7'd4;
  localparam logic [CNT_W-1:0] MAXD_RESET = 12'd64;

  typedef struct packed {
    logic [WPV_W-1:0] words_per_vector;
    logic [CNT_W-1:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] data_word;
    logic [ID_W-1:0]   image_id;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]  match_id;
    logic [CNT_W-1:0] distance_bits;
    logic             within_threshold;
  } result_t;

  function automatic logic [POP_W-1:0] popcount32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w;
    v = (v & 32'h55555555) + ((v >> 1) & 32'h55555555);
    v = (v & 32'h33333333) + ((v >> 2) & 32'h33333333);
    v = (v & 32'h0f0f0f0f) + ((v >> 4) & 32'h0f0f0f0f);
    v = (v & 32'h00ff00ff) + ((v >> 8) & 32'h00ff00ff);
    v = (v & 32'h0000ffff) + ((v >> 16) & 32'h0000ffff);
    return v[POP_W-1:0];
  endfunction

endpackage

[design/htm_cfg.sv]
// APB-style register file: words_per_vector and max_distance.
// Depends on htm_pkg.
module htm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output htm_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.words_per_vector <= htm_pkg::WPV_RESET;
      cfg.max_distance     <= htm_pkg::MAXD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        htm_pkg::REG_WORDS_PER_VECTOR: cfg.words_per_vector <= pwdata[htm_pkg::WPV_W-1:0];
        htm_pkg::REG_MAX_DISTANCE:     cfg.max_distance     <= pwdata[htm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      htm_pkg::REG_WORDS_PER_VECTOR: prdata = 32'(cfg.words_per_vector);
      htm_pkg::REG_MAX_DISTANCE:     prdata = 32'(cfg.max_distance);
      default:                       prdata = '0;
    endcase
  end

endmodule

[design/htm_query_store.sv]
// Query word memory: one write port and one registered read port.
// Depends on htm_pkg; an index beyond the store reads as zero.
module htm_query_store #(
  parameter int WORDS_MAX = 64
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic                       rd_en,
  input  logic [htm_pkg::IDX_W-1:0]  index,
  input  logic [htm_pkg::WORD_W-1:0] wr_data,
  output logic [htm_pkg::WORD_W-1:0] q_word
);

  localparam int AW = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int XW = (AW > htm_pkg::IDX_W) ? AW : htm_pkg::IDX_W;

  logic [htm_pkg::WORD_W-1:0] mem [WORDS_MAX];
  logic [htm_pkg::WORD_W-1:0] rd_data;
  logic                       rd_hit;
  logic [XW-1:0]              index_x;
  logic [AW-1:0]              addr;
  logic                       in_range;

  assign index_x  = XW'(index);
  assign addr     = index_x[AW-1:0];
  assign in_range = int'(index) < WORDS_MAX;

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_hit <= in_range;
      if (in_range) begin
        rd_data <= mem[addr];
      end
    end
  end

  assign q_word = rd_hit ? rd_data : '0;

endmodule

[design/htm_match_stage.sv]
// Compare stage and result register: XOR, popcount, running count, threshold test.
// Depends on htm_pkg; takes the query word read in the same cycle the item was taken.
module htm_match_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  htm_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  htm_pkg::item_t             in_item,
  input  logic [htm_pkg::WORD_W-1:0] q_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output htm_pkg::result_t           out_result,
  output logic                       busy
);

  logic                      s1_valid;
  htm_pkg::item_t            s1_item;
  logic [htm_pkg::CNT_W-1:0] running_count;
  logic [htm_pkg::CNT_W-1:0] count_next;
  logic [htm_pkg::CNT_W:0]   sum;
  logic [htm_pkg::POP_W-1:0] pop;
  logic                      out_free;
  logic                      s1_fire;
  logic                      is_last;
  logic                      is_cmp;

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign busy     = s1_valid;
  assign is_cmp   = s1_item.command == htm_pkg::CMD_COMPARE;

  always_comb begin
    pop = htm_pkg::popcount32(q_word ^ s1_item.data_word);
    // index 0 restarts the count
    if (s1_item.word_index == '0) begin
      sum = (htm_pkg::CNT_W + 1)'(pop);
    end else begin
      sum = (htm_pkg::CNT_W + 1)'(pop) + (htm_pkg::CNT_W + 1)'(running_count);
    end
    count_next = sum[htm_pkg::CNT_W] ? htm_pkg::CNT_MAX : sum[htm_pkg::CNT_W-1:0];
    // index + 1 == words_per_vector covers the zero case as well
    is_last = (htm_pkg::WPV_W'(s1_item.word_index) + htm_pkg::WPV_W'(1)) ==
              cfg.words_per_vector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      running_count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && is_cmp && is_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_fire && is_cmp) begin
        running_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (s1_fire && is_cmp && is_last) begin
      out_result.match_id         <= s1_item.image_id;
      out_result.distance_bits    <= count_next;
      out_result.within_threshold <= count_next <= cfg.max_distance;
    end
  end

endmodule

[design/hamming_threshold_match_top.sv]
// Top level of the Hamming threshold match block: stream ports, APB registers.
// Depends on htm_pkg, htm_cfg, htm_query_store and htm_match_stage.
//
// Usage:
//   s_* stream: s_tuser = command (0 loads a query word, 1 compares a database word),
//   s_tdata = word_index, data_word, image_id. Load the query first, then stream each
//   database descriptor with indexes 0 .. words_per_vector-1.
//   m_* stream: one transaction per descriptor, on the word whose index is
//   words_per_vector-1: m_tdata = match_id, distance_bits; m_tuser = within_threshold.
//   A result is registered on m_* once its last word has left the compare stage.
//   Throughput: one input transaction per cycle while no result is stalled; the query
//   memory is read at the input edge and the popcount-and-add stage follows it.
//   A load followed at once by a compare of the same index sees the new word.
//   Stall: while m_tready is low the result is held, the compare stage holds its word
//   and s_tready drops once that stage is full.
//   Reset (rst, synchronous): clears the running count, empties both stages and sets
//   words_per_vector to 4 and max_distance to 64. The query memory is not cleared;
//   write every query word before comparing against it.
//   Registers: 0x0 words_per_vector, 0x4 max_distance; write them only while idle.
module hamming_threshold_match_top #(
  parameter int WORDS_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // [5:0] word_index, [37:6] data_word, [68:38] image_id
  input  logic        s_tuser,  // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // [30:0] match_id, [42:31] distance_bits
  output logic        m_tuser,  // [0] within_threshold
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  htm_pkg::cfg_t              cfg;
  htm_pkg::item_t             item;
  htm_pkg::result_t           result;
  logic [htm_pkg::WORD_W-1:0] q_word;
  logic                       accept;
  logic                       busy;

  assign item.command    = s_tuser;
  assign item.word_index = s_tdata[5:0];
  assign item.data_word  = s_tdata[37:6];
  assign item.image_id   = s_tdata[68:38];
  assign accept          = s_tvalid && s_tready;

  htm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htm_query_store #(
    .WORDS_MAX (WORDS_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && item.command == htm_pkg::CMD_LOAD),
    .rd_en   (accept && item.command == htm_pkg::CMD_COMPARE),
    .index   (item.word_index),
    .wr_data (item.data_word),
    .q_word  (q_word)
  );

  htm_match_stage u_match (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .q_word     (q_word),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result),
    .busy       (busy)
  );

  assign m_tdata = {5'b0, result.distance_bits, result.match_id};
  assign m_tuser = result.within_threshold;

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !busy)
    else $error("pipeline not empty after reset");

  // input back-pressure only comes from a full compare stage
  a_ready_cause: assert property (@(posedge clk) disable iff (rst) !s_tready |-> busy && m_tvalid)
    else $error("s_tready low without a stalled stage");

  // pass flag agrees with the reported distance
  a_flag_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == (m_tdata[42:31] <= cfg.max_distance))
    else $error("within_threshold disagrees with distance");

  // a result leaves only after its descriptor's last word passed the compare stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy))
    else $error("result without a compared word");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for hamming_threshold_match_top: loads query words, streams database words,
// predicts each descriptor's distance and pass flag, and checks every match transaction.
// Depends on htm_pkg and the design sources; needs no files or arguments.
module tb;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 6;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;  // [5:0] word_index, [37:6] data_word, [68:38] image_id
  logic        s_tuser  = 1'b0;  // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // [30:0] match_id, [42:31] distance_bits
  logic        m_tuser;  // [0] within_threshold
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  hamming_threshold_match_top #(.WORDS_MAX(64)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // distance predictor state
  logic [31:0]      query_mirror [64];
  int unsigned      dist_acc = 0;
  logic [6:0]       cfg_wpv  = htm_pkg::WPV_RESET;
  logic [11:0]      cfg_maxd = htm_pkg::MAXD_RESET;
  htm_pkg::result_t pending_matches [$];

  // stimulus generator state
  logic [31:0]    gen_query [64];
  bit             gen_loaded [64];
  htm_pkg::item_t word_q [$];
  int             queued_words = 0;

  int n_sent = 0;
  int n_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit rcv_ready = 1'b0;
  int rcv_left = 0;
  int cycle_cnt = 0;
  int failures = 0;
  int results_seen = 0;
  int settings_used = 1;

  function automatic void score_word(input htm_pkg::item_t it);
    int unsigned total;
    htm_pkg::result_t r;
    if (it.command == htm_pkg::CMD_LOAD) begin
      query_mirror[it.word_index] = it.data_word;
    end else begin
      total = $countones(query_mirror[it.word_index] ^ it.data_word);
      if (it.word_index != '0) total += dist_acc;
      if (total > int'(htm_pkg::CNT_MAX)) total = htm_pkg::CNT_MAX;
      dist_acc = total;
      // a last index of -1 or above 63 never matches a 6-bit index
      if (cfg_wpv != '0 && {1'b0, it.word_index} == cfg_wpv - 7'd1) begin
        r.match_id         = it.image_id;
        r.distance_bits    = total[11:0];
        r.within_threshold = (total[11:0] <= cfg_maxd);
        pending_matches = {pending_matches, r};
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input htm_pkg::result_t want,
                                 input htm_pkg::result_t got);
    failures++;
    if (failures <= 10)
      $display("mismatch (%s): expected id %h dist %0d pass %0b, got id %h dist %0d pass %0b",
               what, want.match_id, want.distance_bits, want.within_threshold,
               got.match_id, got.distance_bits, got.within_threshold);
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    htm_pkg::result_t got;
    htm_pkg::result_t want;
    htm_pkg::item_t   it;
    cycle_cnt++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.match_id         = m_tdata[30:0];
        got.distance_bits    = m_tdata[42:31];
        got.within_threshold = m_tuser;
        results_seen++;
        if (pending_matches.size() == 0) begin
          report_mismatch("no result pending", '0, got);
        end else begin
          want = pending_matches.pop_front();
          if (got.match_id !== want.match_id || got.distance_bits !== want.distance_bits ||
              got.within_threshold !== want.within_threshold)
            report_mismatch("field", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        it.command    = s_tuser;
        it.word_index = s_tdata[5:0];
        it.data_word  = s_tdata[37:6];
        it.image_id   = s_tdata[68:38];
        score_word(it);
        n_taken++;
      end
    end
  end

  // driver: bursts of transactions with random gaps, hold while not taken
  always @(negedge clk) begin
    htm_pkg::item_t nxt;
    if (!rst && !(s_tvalid && n_taken != n_sent)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        nxt = word_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.command;
        s_tdata  <= {3'b000, nxt.image_id, nxt.data_word, nxt.word_index};
        n_sent++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: alternate ready runs and stalls, with an occasional long ready stretch
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_ready = !rcv_ready;
      if (rcv_ready)
        rcv_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
      else
        rcv_left = $urandom_range(1, 7);
    end else begin
      rcv_left--;
    end
    m_tready <= rcv_ready;
  end

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input int wpv, input int maxd);
    write_register({htm_pkg::REG_WORDS_PER_VECTOR, 2'b00}, 32'(wpv));
    cfg_wpv = wpv[6:0];
    write_register({htm_pkg::REG_MAX_DISTANCE, 2'b00}, 32'(maxd));
    cfg_maxd = maxd[11:0];
    settings_used++;
  endtask

  task automatic queue_word(input logic cmd, input int idx, input logic [31:0] w,
                            input logic [30:0] id);
    htm_pkg::item_t it;
    it.command    = cmd;
    it.word_index = idx[5:0];
    it.data_word  = w;
    it.image_id   = id;
    word_q = {word_q, it};
    queued_words++;
    if (cmd == htm_pkg::CMD_LOAD) begin
      gen_query[idx]  = w;
      gen_loaded[idx] = 1'b1;
    end
  endtask

  function automatic logic [31:0] query_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // database word: equal, inverted, a few flipped bits, or unrelated
  function automatic logic [31:0] db_word(input int idx);
    case ($urandom_range(0, 5))
      0: return gen_query[idx];
      1: return ~gen_query[idx];
      2, 3: return gen_query[idx] ^ ($urandom() & $urandom() & $urandom());
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_descriptor(input int first, input int last);
    logic [30:0] id;
    id = 31'($urandom());
    for (int i = first; i <= last; i++) queue_word(htm_pkg::CMD_COMPARE, i, db_word(i), id);
  endtask

  // broken sequences and stray transactions
  task automatic queue_noise(input int len);
    int idx;
    case ($urandom_range(0, 3))
      0: queue_descriptor(0, $urandom_range(0, len - 1));
      1: queue_descriptor((len > 1) ? $urandom_range(1, len - 1) : 0, len - 1);
      2: begin
        idx = $urandom_range(0, 63);
        while (!gen_loaded[idx]) idx = $urandom_range(0, 63);
        queue_word(htm_pkg::CMD_COMPARE, idx, db_word(idx), 31'($urandom()));
      end
      default: queue_word(htm_pkg::CMD_LOAD, $urandom_range(0, 63), query_word(),
                          31'($urandom()));
    endcase
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || n_taken != n_sent || pending_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_threshold(input int wpv);
    int t;
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 2048;
      2: return 4095;
      3: return $urandom_range(0, 4095);
      default: begin
        t = wpv * 16 + $urandom_range(0, 8) - 4;
        return (t < 0) ? 0 : t;
      end
    endcase
  endfunction

  initial begin
    logic [31:0] flip_mask [4];
    int wpv;
    int maxd;
    int len;
    int budget;
    int phase;
    int start_cnt;
    int directed_cnt;
    bit reload;
    for (int i = 0; i < 64; i++) gen_loaded[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset settings: four words, threshold 64
    queue_word(htm_pkg::CMD_LOAD, 0, 32'h0000_0000, 31'h0000_0000);
    queue_word(htm_pkg::CMD_LOAD, 1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    queue_word(htm_pkg::CMD_LOAD, 2, 32'hA5A5_A5A5, 31'h0000_0000);
    queue_word(htm_pkg::CMD_LOAD, 3, 32'h1234_5678, 31'h0000_0000);
    for (int i = 0; i < 4; i++)
      queue_word(htm_pkg::CMD_COMPARE, i, gen_query[i], 31'h0000_0000);
    for (int i = 0; i < 4; i++)
      queue_word(htm_pkg::CMD_COMPARE, i, ~gen_query[i], 31'h7FFF_FFFF);
    // reload word 0 right before it is compared
    queue_word(htm_pkg::CMD_LOAD, 0, 32'hC3C3_C3C3, 31'h5555_5555);
    flip_mask[0] = 32'hFFFF_FFFF;
    flip_mask[1] = 32'hFFFF_0000;
    flip_mask[2] = 32'h0000_FF00;
    flip_mask[3] = 32'h0000_00FF;
    for (int i = 0; i < 4; i++)
      queue_word(htm_pkg::CMD_COMPARE, i, gen_query[i] ^ flip_mask[i], 31'h1234_5678);
    flip_mask[3] = 32'h0000_01FF;
    for (int i = 0; i < 4; i++)
      queue_word(htm_pkg::CMD_COMPARE, i, gen_query[i] ^ flip_mask[i], 31'h2AAA_AAAA);
    // continue the last count without restarting at index 0
    for (int i = 1; i < 4; i++)
      queue_word(htm_pkg::CMD_COMPARE, i, ~gen_query[i], 31'h0F0F_0F0F);
    queue_word(htm_pkg::CMD_LOAD, 63, $urandom(), 31'h0000_0001);
    wait_idle();
    directed_cnt = queued_words;

    phase = 0;
    while (queued_words - directed_cnt < RANDOM_ITEMS) begin
      case (phase)
        0: begin wpv = 1;   maxd = 16;   end
        1: begin wpv = 64;  maxd = 1024; end
        2: begin wpv = 64;  maxd = 4095; end
        3: begin wpv = 0;   maxd = 64;   end
        4: begin wpv = 127; maxd = 0;    end
        5: begin wpv = 8;   maxd = 0;    end
        6: begin wpv = 2;   maxd = 2048; end
        default: begin
          wpv  = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
          maxd = pick_threshold(wpv);
        end
      endcase
      set_limits(wpv, maxd);
      len = (wpv >= 1 && wpv <= 64) ? wpv : $urandom_range(1, 8);

      reload = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) if (!gen_loaded[i]) reload = 1'b1;
      if (reload)
        for (int i = 0; i < len; i++)
          queue_word(htm_pkg::CMD_LOAD, i, query_word(), 31'($urandom()));

      if (phase == 2) begin
        // drive the count into saturation: every word differs in all 32 bits
        queue_word(htm_pkg::CMD_COMPARE, 0, ~gen_query[0], 31'h3C3C_3C3C);
        repeat (140) begin
          start_cnt = $urandom_range(1, 62);
          queue_word(htm_pkg::CMD_COMPARE, start_cnt, ~gen_query[start_cnt], 31'h3C3C_3C3C);
        end
        queue_word(htm_pkg::CMD_COMPARE, 63, ~gen_query[63], 31'h3C3C_3C3C);
      end

      start_cnt = queued_words;
      budget = $urandom_range(60, 200);
      if (budget > RANDOM_ITEMS - (queued_words - directed_cnt))
        budget = RANDOM_ITEMS - (queued_words - directed_cnt);
      while (queued_words - start_cnt < budget) begin
        if ($urandom_range(0, 7) != 0) queue_descriptor(0, len - 1);
        else queue_noise(len);
      end
      wait_idle();
      phase++;
    end

    if (pending_matches.size() != 0) begin
      $display("%0d expected results never arrived", pending_matches.size());
      failures += pending_matches.size();
    end
    $display("summary: %0d words streamed across %0d register settings, %0d results checked",
             n_taken, settings_used, results_seen);
    $display("summary: %0d failures in %0d cycles", failures, cycle_cnt);
    if (failures == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("tb NOT OK");
    $finish;
  end

endmodule
